FILE: rtl/bole_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Operation and status codes, the cell control bundle and default sizes.
// ----------------------------------------------------------------------------
package bole_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VAL_W        = 32;

	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_DELETE    = 2'd2,
		OP_TRAVERSE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_ELEMENT   = 3'd4
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic ins_front;
		logic ins_back;
		logic rotate;
		logic drop;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/bounded_ordered_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of signed values in a cell chain
// An insert, or any request on an empty list, answers in the cycle after
// acceptance and busy stays low, so a request can be accepted every cycle.
// Delete and traverse rotate the chain once per entry and hold busy high
// until the walk ends; the next request is accepted once busy is low. Traverse
// results come one per cycle, final result in the cycle busy falls.
// Results cannot be stalled by the receiver.
// Reset clears the count and control state; cell contents are left as is.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
	parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [1:0]                         opcode,
	input  wire  signed [bole_pkg::VAL_W-1:0]  operand_value,
	output logic                               result_valid,
	output logic signed [bole_pkg::VAL_W-1:0]  result_value,
	output logic [2:0]                         status,
	output logic                               last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t                      state_q;
	bole_pkg::op_t               op_q;
	logic [bole_pkg::VAL_W-1:0]  key_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            steps_q;
	logic                        found_q;
	logic                        valid_q;
	logic [bole_pkg::VAL_W-1:0]  value_q;
	logic [2:0]                  status_q;
	logic                        last_q;

	logic [bole_pkg::VAL_W-1:0]  vals [CAPACITY];
	bole_pkg::cell_ctl_t         ctl;
	logic [CNT_W-1:0]            tail;
	logic                        accept;
	logic                        full;
	logic                        hit;
	logic                        final_step;
	logic                        walking;

	assign accept     = start && !busy;
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign tail       = count_q - CNT_W'(1);
	assign walking    = (state_q == S_WALK);
	assign hit        = (op_q == bole_pkg::OP_DELETE) && !found_q && (vals[0] == key_q);
	assign final_step = (steps_q == CNT_W'(1));
	assign busy       = walking;

	always_comb begin
		ctl           = '0;
		ctl.ins_front = accept && !full && (opcode == bole_pkg::OP_INS_FRONT);
		ctl.ins_back  = accept && !full && (opcode == bole_pkg::OP_INS_BACK);
		ctl.rotate    = walking;
		ctl.drop      = walking && hit;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [bole_pkg::VAL_W-1:0] left_v;
		logic [bole_pkg::VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = vals[i];
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end
		bole_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.cnt     (count_q),
			.tail    (tail),
			.operand (operand_value),
			.left    (left_v),
			.right   (right_v),
			.head    (vals[0]),
			.value   (vals[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= bole_pkg::OP_INS_FRONT;
			count_q  <= '0;
			steps_q  <= '0;
			found_q  <= 1'b0;
			valid_q  <= 1'b0;
			status_q <= bole_pkg::ST_DONE;
			last_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= bole_pkg::op_t'(opcode);
						found_q <= 1'b0;
						steps_q <= count_q;
						last_q  <= 1'b1;
						case (bole_pkg::op_t'(opcode))
							bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK: begin
								valid_q <= 1'b1;
								if (full) begin
									status_q <= bole_pkg::ST_FULL;
								end else begin
									status_q <= bole_pkg::ST_DONE;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							bole_pkg::OP_DELETE: begin
								if (count_q == '0) begin
									valid_q  <= 1'b1;
									status_q <= bole_pkg::ST_NOT_FOUND;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
								if (count_q == '0) begin
									valid_q  <= 1'b1;
									status_q <= bole_pkg::ST_EMPTY;
								end else begin
									state_q <= S_WALK;
								end
							end
						endcase
					end
				end
				S_WALK: begin
					steps_q <= steps_q - CNT_W'(1);
					if (hit) begin
						found_q <= 1'b1;
						count_q <= count_q - CNT_W'(1);
					end
					if (op_q == bole_pkg::OP_TRAVERSE) begin
						valid_q  <= 1'b1;
						status_q <= bole_pkg::ST_ELEMENT;
						last_q   <= final_step;
					end else if (final_step) begin
						valid_q  <= 1'b1;
						last_q   <= 1'b1;
						status_q <= (found_q || hit) ? bole_pkg::ST_DONE
						                             : bole_pkg::ST_NOT_FOUND;
					end
					if (final_step) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// element payload only carries data during traverse
	always_ff @(posedge clk) begin
		if (walking && op_q == bole_pkg::OP_TRAVERSE) begin
			value_q <= vals[0];
		end else begin
			value_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= operand_value;
		end
	end

	assign result_valid = valid_q;
	assign result_value = value_q;
	assign status       = status_q;
	assign last         = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count exceeds capacity");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("final result while still walking");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last))
		else $error("walk ended without a final result");

	a_empty_trav: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == bole_pkg::OP_TRAVERSE && count_q == '0)
		|=> (result_valid && last && status == bole_pkg::ST_EMPTY))
		else $error("empty traverse did not answer list empty");

endmodule
`default_nettype wire

FILE: rtl/bole_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bole_cell: one entry of the list chain
// Holds one value; shifts toward the back on insert at front, loads on
// insert at back, and shifts toward the front on a rotate step.
// ----------------------------------------------------------------------------
module bole_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  wire                          clk,
	input  wire  bole_pkg::cell_ctl_t    ctl,
	input  wire  [CNT_W-1:0]             cnt,
	input  wire  [CNT_W-1:0]             tail,
	input  wire  [bole_pkg::VAL_W-1:0]   operand,
	input  wire  [bole_pkg::VAL_W-1:0]   left,
	input  wire  [bole_pkg::VAL_W-1:0]   right,
	input  wire  [bole_pkg::VAL_W-1:0]   head,
	output logic [bole_pkg::VAL_W-1:0]   value
);

	logic [bole_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_front) begin
			value_q <= (IDX == 0) ? operand : left;
		end else if (ctl.ins_back && cnt == CNT_W'(IDX)) begin
			value_q <= operand;
		end else if (ctl.rotate) begin
			// kept head wraps to the tail, everything else moves up one
			if (!ctl.drop && tail == CNT_W'(IDX)) begin
				value_q <= head;
			end else begin
				value_q <= right;
			end
		end
	end

	assign value = value_q;

endmodule
`default_nettype wire

FILE: test/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_tb: self-checking bench for the list engine
// Sends insert, delete and traverse requests with random gaps, keeps its own
// mirror of the list and checks every result strobe in order, field by field.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_tb;

	localparam int CAP          = bole_pkg::CAPACITY_DEF;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 346;
	localparam int CALM_ITEMS   = 60;
	localparam int POOL_SIZE    = 64;
	localparam int DIRECTED_N   = 24;

	typedef struct {
		logic signed [bole_pkg::VAL_W-1:0] value;
		bole_pkg::status_t                 st;
		logic                              last;
	} list_result_t;

	typedef struct {
		bole_pkg::op_t                     op;
		logic signed [bole_pkg::VAL_W-1:0] value;
		logic                              typed;
		bole_pkg::status_t                 st;
	} list_request_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [1:0]                        opcode;
	logic signed [bole_pkg::VAL_W-1:0] operand_value;
	logic                              result_valid;
	logic signed [bole_pkg::VAL_W-1:0] result_value;
	logic [2:0]                        status;
	logic                              last;

	// expectation typed into the table travels with the request
	logic                              req_typed;
	bole_pkg::status_t                 req_status;

	logic signed [bole_pkg::VAL_W-1:0] list_mirror [CAP];
	int                                mirror_count;
	list_result_t                      pending_results [$];
	int                                fail_count;
	int                                report_count;
	int                                quiet_cycles;

	logic signed [bole_pkg::VAL_W-1:0] key_pool [POOL_SIZE];
	int                                pool_n;
	list_request_t                     directed_rows [DIRECTED_N];

	bounded_ordered_list_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.operand_value(operand_value),
		.result_valid (result_valid),
		.result_value (result_value),
		.status       (status),
		.last         (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// mirror of the list: applies one request and queues the results it causes
	function automatic void apply_list_op(input bole_pkg::op_t op,
			input logic signed [bole_pkg::VAL_W-1:0] v);
		int hit;
		hit = -1;
		case (op)
		bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK: begin
			if (mirror_count >= CAP) begin
				pending_results.push_back('{value: '0, st: bole_pkg::ST_FULL, last: 1'b1});
			end else begin
				if (op == bole_pkg::OP_INS_FRONT) begin
					for (int i = mirror_count; i > 0; i--)
						list_mirror[i] = list_mirror[i-1];
					list_mirror[0] = v;
				end else begin
					list_mirror[mirror_count] = v;
				end
				mirror_count++;
				pending_results.push_back('{value: '0, st: bole_pkg::ST_DONE, last: 1'b1});
			end
		end
		bole_pkg::OP_DELETE: begin
			for (int i = 0; i < mirror_count; i++)
				if (hit < 0 && list_mirror[i] == v)
					hit = i;
			if (hit < 0) begin
				pending_results.push_back('{value: '0, st: bole_pkg::ST_NOT_FOUND,
					last: 1'b1});
			end else begin
				for (int i = hit; i + 1 < mirror_count; i++)
					list_mirror[i] = list_mirror[i+1];
				mirror_count--;
				pending_results.push_back('{value: '0, st: bole_pkg::ST_DONE, last: 1'b1});
			end
		end
		default: begin
			if (mirror_count == 0)
				pending_results.push_back('{value: '0, st: bole_pkg::ST_EMPTY, last: 1'b1});
			for (int i = 0; i < mirror_count; i++)
				pending_results.push_back('{value: list_mirror[i],
					st: bole_pkg::ST_ELEMENT, last: (i + 1 == mirror_count)});
		end
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		list_result_t want;
		logic         moved;
		moved = 1'b0;
		if (arst_n === 1'b1) begin
			if (result_valid === 1'b1) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (report_count < MAX_REPORTS)
						$display("unexpected result: value %0d status %0d last %0b",
							result_value, status, last);
					report_count++;
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value || status !== want.st || last !== want.last) begin
						fail_count++;
						if (report_count < MAX_REPORTS)
							$display("mismatch: value %0d/%0d status %0d/%0d last %0b/%0b",
								want.value, result_value, want.st, status, want.last, last);
						report_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				moved = 1'b1;
				apply_list_op(bole_pkg::op_t'(opcode), operand_value);
				if (req_typed)
					pending_results[pending_results.size() - 1] =
						'{value: '0, st: req_status, last: 1'b1};
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(input bole_pkg::op_t op,
			input logic signed [bole_pkg::VAL_W-1:0] v,
			input logic typed, input bole_pkg::status_t st);
		start         <= 1'b1;
		opcode        <= op;
		operand_value <= v;
		req_typed     <= typed;
		req_status    <= st;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic maybe_idle(input logic calm);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic remember_key(input logic signed [bole_pkg::VAL_W-1:0] v);
		if (pool_n < POOL_SIZE) begin
			key_pool[pool_n] = v;
			pool_n++;
		end else begin
			key_pool[$urandom_range(0, POOL_SIZE - 1)] = v;
		end
	endtask

	initial begin
		bole_pkg::op_t                     op;
		logic signed [bole_pkg::VAL_W-1:0] v;
		int                                roll;
		int                                ins_pct;
		int                                del_pct;
		int                                slot;
		logic                              calm;

		arst_n        <= 1'b0;
		start         <= 1'b0;
		opcode        <= bole_pkg::OP_INS_FRONT;
		operand_value <= '0;
		req_typed     <= 1'b0;
		req_status    <= bole_pkg::ST_DONE;
		mirror_count  = 0;
		fail_count    = 0;
		report_count  = 0;
		quiet_cycles  = 0;
		pool_n        = 0;

		// the list goes through duplicates, both ends, the middle and back to empty
		directed_rows = '{
			'{bole_pkg::OP_TRAVERSE,  32'sh00000000, 1'b1, bole_pkg::ST_EMPTY},
			'{bole_pkg::OP_DELETE,    32'sh00000005, 1'b1, bole_pkg::ST_NOT_FOUND},
			'{bole_pkg::OP_INS_FRONT, 32'sh7FFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_BACK,  32'sh80000000, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_FRONT, 32'sh00000000, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_BACK,  32'shFFFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_BACK,  32'sh7FFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_TRAVERSE,  32'sh00000000, 1'b0, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'sh7FFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_TRAVERSE,  32'sh00000000, 1'b0, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'sh7FFFFFFE, 1'b1, bole_pkg::ST_NOT_FOUND},
			'{bole_pkg::OP_DELETE,    32'sh80000000, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_FRONT, 32'sh55555555, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_INS_BACK,  32'shAAAAAAAA, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_TRAVERSE,  32'shFFFFFFFF, 1'b0, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'shAAAAAAAA, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'sh00000000, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'sh55555555, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'shFFFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_DELETE,    32'sh7FFFFFFF, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_TRAVERSE,  32'sh00000000, 1'b1, bole_pkg::ST_EMPTY},
			'{bole_pkg::OP_DELETE,    32'sh7FFFFFFF, 1'b1, bole_pkg::ST_NOT_FOUND},
			'{bole_pkg::OP_INS_BACK,  32'sh12345678, 1'b1, bole_pkg::ST_DONE},
			'{bole_pkg::OP_TRAVERSE,  32'sh00000000, 1'b0, bole_pkg::ST_DONE}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIRECTED_N; n++) begin
			send_request(directed_rows[n].op, directed_rows[n].value,
				directed_rows[n].typed, directed_rows[n].st);
			maybe_idle(1'b0);
		end

		// grow to full, drain to empty, grow again, then a mixed tail
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if (n < 90 || (n >= 170 && n < 250)) begin
				ins_pct = 65;
				del_pct = 80;
			end else if (n < 170) begin
				ins_pct = 12;
				del_pct = 88;
			end else begin
				ins_pct = 40;
				del_pct = 75;
			end
			roll = $urandom_range(0, 99);
			if (roll < ins_pct) begin
				op = ($urandom_range(0, 1) == 0) ? bole_pkg::OP_INS_FRONT
				                                 : bole_pkg::OP_INS_BACK;
				case ($urandom_range(0, 7))
				0: begin
					v = ($urandom_range(0, 1) == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
				end
				1: begin
					v = ($urandom_range(0, 1) == 0) ? 32'sh00000000 : 32'shFFFFFFFF;
				end
				2, 3: begin
					// duplicates of values already seen
					v = (pool_n > 0) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
				end
				default: begin
					v = $urandom;
				end
				endcase
				remember_key(v);
			end else if (roll < del_pct) begin
				op = bole_pkg::OP_DELETE;
				if (pool_n > 0 && $urandom_range(0, 9) < 8) begin
					slot = $urandom_range(0, pool_n - 1);
					v = key_pool[slot];
					key_pool[slot] = key_pool[pool_n - 1];
					pool_n--;
				end else begin
					v = $urandom;
				end
			end else begin
				op = bole_pkg::OP_TRAVERSE;
				v = $urandom;
			end
			send_request(op, v, 1'b0, bole_pkg::ST_DONE);
			maybe_idle(calm);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CAP + 8) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
test/bounded_ordered_list_engine_tb.sv
